/* rtl/core/pit_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

  localparam int unsigned NumVerts  = 3;
  localparam int unsigned NumAxes   = 3;
  // register stages from an accepted transaction to the result strobe
  localparam int unsigned PipeDepth = 6;

endpackage

`default_nettype wire

/* rtl/core/point_in_triangle_test.sv */
// Three-dimensional point-in-triangle test on signed fixed-point coordinates,
// exact at full width with no rounding. A transaction is taken at every clock
// edge with start_i high; busy_o is always low, so a new transaction may follow
// in every cycle. Each transaction gives one result: inside_res_o is valid
// while done_o is high, for that one cycle only, and the receiver cannot
// stall it. The six stages are
// the edge and point differences, the cross-product multiplies, the cross-product
// subtracts, the split partial products of the three dot products, the
// recombination of those partial products and the final sum and sign test.
// Points on an edge or vertex and triangles collapsed to a single point report inside.
`timescale 1ns / 1ps
`default_nettype none

module point_in_triangle_test import pit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] vertex0_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex0_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex0_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex1_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex1_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex1_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex2_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex2_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex2_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                               done_o,
  output logic                               inside_res_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DW  = W + 1;          // difference width
  localparam int unsigned MW  = 2 * DW;         // cross product term width
  localparam int unsigned CW  = MW + 1;         // cross product component width
  localparam int unsigned LW  = (CW + 1) / 2;   // low slice of a split component
  localparam int unsigned HW  = CW - LW;        // high slice, signed
  localparam int unsigned PW  = 2 * CW;         // dot product term width
  localparam int unsigned SW  = PW + 2;         // dot product sum width

  logic signed [W-1:0] vert [NumVerts][NumAxes];
  logic signed [W-1:0] pt   [NumAxes];

  assign vert[0][0] = vertex0_x_i;
  assign vert[0][1] = vertex0_y_i;
  assign vert[0][2] = vertex0_z_i;
  assign vert[1][0] = vertex1_x_i;
  assign vert[1][1] = vertex1_y_i;
  assign vert[1][2] = vertex1_z_i;
  assign vert[2][0] = vertex2_x_i;
  assign vert[2][1] = vertex2_y_i;
  assign vert[2][2] = vertex2_z_i;
  assign pt[0]      = point_x_i;
  assign pt[1]      = point_y_i;
  assign pt[2]      = point_z_i;

  // valid chain
  logic [PipeDepth-1:0] vld_d, vld_q;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[PipeDepth-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[PipeDepth-1];

  // stage 1: edge and vertex-to-point differences
  logic signed [DW-1:0] edge_d [NumVerts][NumAxes], edge_q [NumVerts][NumAxes];
  logic signed [DW-1:0] topt_d [NumVerts][NumAxes], topt_q [NumVerts][NumAxes];
  // stage 2: cross product terms
  logic signed [MW-1:0] xa_d [NumVerts][NumAxes], xa_q [NumVerts][NumAxes];
  logic signed [MW-1:0] xb_d [NumVerts][NumAxes], xb_q [NumVerts][NumAxes];
  // stage 3: cross product components
  logic signed [CW-1:0] cp_d [NumVerts][NumAxes], cp_q [NumVerts][NumAxes];
  // stage 4: partial products of the dot products
  logic signed [2*HW-1:0]   hh_d [NumVerts][NumAxes], hh_q [NumVerts][NumAxes];
  logic signed [HW+LW:0]    hl_d [NumVerts][NumAxes], hl_q [NumVerts][NumAxes];
  logic signed [HW+LW:0]    lh_d [NumVerts][NumAxes], lh_q [NumVerts][NumAxes];
  logic        [2*LW-1:0]   ll_d [NumVerts][NumAxes], ll_q [NumVerts][NumAxes];
  // stage 5: dot product terms
  logic signed [PW-1:0] term_d [NumVerts][NumAxes], term_q [NumVerts][NumAxes];
  // stage 6: sign test
  logic [NumVerts-1:0] nonneg;
  logic                inside_d, inside_q;

  for (genvar gi = 0; gi < NumVerts; gi++) begin : g_vtx
    localparam int unsigned Nx = (gi + 1) % NumVerts;
    for (genvar gk = 0; gk < NumAxes; gk++) begin : g_ax
      localparam int unsigned K1 = (gk + 1) % NumAxes;
      localparam int unsigned K2 = (gk + 2) % NumAxes;

      logic signed [HW-1:0] a_hi, b_hi;
      logic        [LW-1:0] a_lo, b_lo;

      assign edge_d[gi][gk] = {vert[Nx][gk][W-1], vert[Nx][gk]}
                            - {vert[gi][gk][W-1], vert[gi][gk]};
      assign topt_d[gi][gk] = {pt[gk][W-1], pt[gk]}
                            - {vert[gi][gk][W-1], vert[gi][gk]};

      assign xa_d[gi][gk] = MW'(edge_q[gi][K1]) * MW'(topt_q[gi][K2]);
      assign xb_d[gi][gk] = MW'(edge_q[gi][K2]) * MW'(topt_q[gi][K1]);

      assign cp_d[gi][gk] = CW'(xa_q[gi][gk]) - CW'(xb_q[gi][gk]);

      // dot product gi pairs cross product gi with the next one
      assign a_hi = cp_q[gi][gk][CW-1:LW];
      assign a_lo = cp_q[gi][gk][LW-1:0];
      assign b_hi = cp_q[Nx][gk][CW-1:LW];
      assign b_lo = cp_q[Nx][gk][LW-1:0];

      assign hh_d[gi][gk] = (2*HW)'(a_hi) * (2*HW)'(b_hi);
      assign hl_d[gi][gk] = (HW+LW+1)'(a_hi) * (HW+LW+1)'($signed({1'b0, b_lo}));
      assign lh_d[gi][gk] = (HW+LW+1)'(b_hi) * (HW+LW+1)'($signed({1'b0, a_lo}));
      assign ll_d[gi][gk] = (2*LW)'(a_lo) * (2*LW)'(b_lo);

      assign term_d[gi][gk] = (PW'(hh_q[gi][gk]) <<< (2 * LW))
                            + ((PW'(hl_q[gi][gk]) + PW'(lh_q[gi][gk])) <<< LW)
                            + PW'($signed({1'b0, ll_q[gi][gk]}));
    end

    logic signed [SW-1:0] dot_sum;
    assign dot_sum = SW'(term_q[gi][0]) + SW'(term_q[gi][1]) + SW'(term_q[gi][2]);
    assign nonneg[gi] = ~dot_sum[SW-1];
  end

  assign inside_d = &nonneg;

  always_ff @(posedge clk_i) begin
    edge_q   <= edge_d;
    topt_q   <= topt_d;
    xa_q     <= xa_d;
    xb_q     <= xb_d;
    cp_q     <= cp_d;
    hh_q     <= hh_d;
    hl_q     <= hl_d;
    lh_q     <= lh_d;
    ll_q     <= ll_d;
    term_q   <= term_d;
    inside_q <= inside_d;
  end

  assign inside_res_o = inside_q;

endmodule

`default_nettype wire

/* rtl/core/pit_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pit_checker import pit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic signed [COORD_WIDTH-1:0] vertex0_x_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex0_y_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex0_z_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex1_x_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex1_y_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex1_z_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex2_x_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex2_y_i,
  input wire logic signed [COORD_WIDTH-1:0] vertex2_z_i,
  input wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input wire logic signed [COORD_WIDTH-1:0] point_z_i,
  input wire logic                          done_o,
  input wire logic                          inside_res_o
);

  logic taken;
  logic pt_at_v0, pt_at_v1, pt_at_v2, pt_at_vtx;
  logic v0_is_v1, v1_is_v2, vtx_same;

  assign taken    = start_i && !busy_o && rst_ni;

  assign pt_at_v0 = (point_x_i == vertex0_x_i) && (point_y_i == vertex0_y_i)
                 && (point_z_i == vertex0_z_i);
  assign pt_at_v1 = (point_x_i == vertex1_x_i) && (point_y_i == vertex1_y_i)
                 && (point_z_i == vertex1_z_i);
  assign pt_at_v2 = (point_x_i == vertex2_x_i) && (point_y_i == vertex2_y_i)
                 && (point_z_i == vertex2_z_i);
  assign pt_at_vtx = pt_at_v0 || pt_at_v1 || pt_at_v2;

  assign v0_is_v1 = (vertex0_x_i == vertex1_x_i) && (vertex0_y_i == vertex1_y_i)
                 && (vertex0_z_i == vertex1_z_i);
  assign v1_is_v2 = (vertex1_x_i == vertex2_x_i) && (vertex1_y_i == vertex2_y_i)
                 && (vertex1_z_i == vertex2_z_i);
  assign vtx_same = v0_is_v1 && v1_is_v2;

  // one result per transaction, delayed by the PipeDepth register stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(taken, PipeDepth))
    else $error("result strobe does not follow its transaction");

  // a point on a vertex lies on the triangle
  a_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(taken && pt_at_vtx, PipeDepth)) |-> inside_res_o)
    else $error("point on a vertex reported outside");

  // a triangle collapsed to a point has zero cross products
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(taken && vtx_same, PipeDepth)) |-> inside_res_o)
    else $error("collapsed triangle reported outside");

endmodule

bind point_in_triangle_test pit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pit_checker (.*);

`default_nettype wire

/* tb/tb_point_in_triangle_test.sv */
`timescale 1ns / 1ps

module tb_point_in_triangle_test;
  import pit_pkg::*;

  localparam int CW = 16;
  localparam int StallLimit = 2000;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [NumVerts-1:0][NumAxes-1:0][CW-1:0] vert;
    logic [NumAxes-1:0][CW-1:0]               pt;
  } query_t;

  class inside_tracker;
    logic verdicts_due[$];
    int   faults;

    function automatic logic point_inside(query_t q);
      logic signed [127:0] vx[NumVerts][NumAxes];
      logic signed [127:0] p[NumAxes];
      logic signed [127:0] e[NumAxes];
      logic signed [127:0] d[NumAxes];
      logic signed [127:0] c[NumVerts][NumAxes];
      logic signed [127:0] s;
      logic ok;
      int nx;
      for (int i = 0; i < NumVerts; i++) begin
        for (int k = 0; k < NumAxes; k++) begin
          vx[i][k] = $signed(q.vert[i][k]);
        end
      end
      for (int k = 0; k < NumAxes; k++) begin
        p[k] = $signed(q.pt[k]);
      end
      for (int i = 0; i < NumVerts; i++) begin
        nx = (i + 1) % NumVerts;
        for (int k = 0; k < NumAxes; k++) begin
          e[k] = vx[nx][k] - vx[i][k];
          d[k] = p[k] - vx[i][k];
        end
        c[i][0] = e[1] * d[2] - e[2] * d[1];
        c[i][1] = e[2] * d[0] - e[0] * d[2];
        c[i][2] = e[0] * d[1] - e[1] * d[0];
      end
      ok = 1'b1;
      for (int i = 0; i < NumVerts; i++) begin
        nx = (i + 1) % NumVerts;
        s = c[i][0] * c[nx][0] + c[i][1] * c[nx][1] + c[i][2] * c[nx][2];
        if (s < 0) ok = 1'b0;
      end
      return ok;
    endfunction

    function void log_query(query_t q);
      verdicts_due.push_back(point_inside(q));
    endfunction

    function void check_verdict(logic got);
      logic want;
      if (verdicts_due.size() == 0) begin
        faults++;
        if (faults <= MaxReports) $display("unexpected result: inside_res=%b", got);
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= MaxReports) begin
          $display("inside_res mismatch: expected %b, got %b", want, got);
        end
      end
    endfunction

    function bit clean();
      return faults == 0 && verdicts_due.size() == 0;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [CW-1:0] vertex0_x_i = '0;
  logic signed [CW-1:0] vertex0_y_i = '0;
  logic signed [CW-1:0] vertex0_z_i = '0;
  logic signed [CW-1:0] vertex1_x_i = '0;
  logic signed [CW-1:0] vertex1_y_i = '0;
  logic signed [CW-1:0] vertex1_z_i = '0;
  logic signed [CW-1:0] vertex2_x_i = '0;
  logic signed [CW-1:0] vertex2_y_i = '0;
  logic signed [CW-1:0] vertex2_z_i = '0;
  logic signed [CW-1:0] point_x_i = '0;
  logic signed [CW-1:0] point_y_i = '0;
  logic signed [CW-1:0] point_z_i = '0;
  logic done_o;
  logic inside_res_o;

  inside_tracker tracker = new();
  int idle_pct = 29;
  int stall_cycles = 0;

  point_in_triangle_test #(
    .COORD_WIDTH(CW)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .vertex0_x_i (vertex0_x_i),
    .vertex0_y_i (vertex0_y_i),
    .vertex0_z_i (vertex0_z_i),
    .vertex1_x_i (vertex1_x_i),
    .vertex1_y_i (vertex1_y_i),
    .vertex1_z_i (vertex1_z_i),
    .vertex2_x_i (vertex2_x_i),
    .vertex2_y_i (vertex2_y_i),
    .vertex2_z_i (vertex2_z_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .done_o      (done_o),
    .inside_res_o(inside_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_verdict(inside_res_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic query_t pack_query(int v[NumVerts][NumAxes], int p[NumAxes]);
    query_t q;
    for (int i = 0; i < NumVerts; i++) begin
      for (int k = 0; k < NumAxes; k++) begin
        q.vert[i][k] = v[i][k][CW-1:0];
      end
    end
    for (int k = 0; k < NumAxes; k++) begin
      q.pt[k] = p[k][CW-1:0];
    end
    return q;
  endfunction

  function automatic query_t make_query(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, int px, int py, int pz);
    int v[NumVerts][NumAxes];
    int p[NumAxes];
    v[0] = '{ax, ay, az};
    v[1] = '{bx, by, bz};
    v[2] = '{cx, cy, cz};
    p = '{px, py, pz};
    return pack_query(v, p);
  endfunction

  function automatic query_t random_query();
    int v[NumVerts][NumAxes];
    int p[NumAxes];
    int d[NumAxes];
    int span;
    int mode;
    int axis;
    int lvl;
    int sel;
    int m;
    mode = $urandom_range(99);
    span = 1 << $urandom_range(4, 14);
    for (int i = 0; i < NumVerts; i++) begin
      for (int k = 0; k < NumAxes; k++) begin
        v[i][k] = pick(-span, span - 1);
      end
    end
    for (int k = 0; k < NumAxes; k++) begin
      p[k] = pick(-span, span - 1);
    end
    if (mode < 20) begin
      // raw words, every bit free
      for (int i = 0; i < NumVerts; i++) begin
        for (int k = 0; k < NumAxes; k++) begin
          v[i][k] = int'($urandom());
        end
      end
      for (int k = 0; k < NumAxes; k++) begin
        p[k] = int'($urandom());
      end
    end else if (mode < 45) begin
      // triangle in an axis-aligned plane, point near the centroid in that plane
      axis = $urandom_range(2);
      lvl = pick(-32768, 32767);
      for (int i = 0; i < NumVerts; i++) v[i][axis] = lvl;
      for (int k = 0; k < NumAxes; k++) begin
        p[k] = (v[0][k] + v[1][k] + v[2][k]) / 3 + pick(-span / 2, span / 2);
      end
      p[axis] = lvl;
    end else if (mode < 60) begin
      // point on an edge midpoint or on a vertex
      for (int k = 0; k < NumAxes; k++) begin
        d[k] = pick(-span / 2, span / 2);
        v[1][k] = v[0][k] + 2 * d[k];
      end
      sel = $urandom_range(3);
      for (int k = 0; k < NumAxes; k++) begin
        p[k] = (sel == 3) ? v[0][k] + d[k] : v[sel][k];
      end
    end else if (mode < 70) begin
      // collinear or coincident vertices
      m = pick(-3, 3);
      for (int k = 0; k < NumAxes; k++) begin
        d[k] = pick(-1024, 1023);
        v[1][k] = v[0][k] + d[k];
        v[2][k] = v[0][k] + m * d[k];
      end
    end else if (mode < 80) begin
      for (int i = 0; i < NumVerts + 1; i++) begin
        for (int k = 0; k < NumAxes; k++) begin
          case ($urandom_range(4))
            0: lvl = -32768;
            1: lvl = 32767;
            2: lvl = 0;
            3: lvl = -1;
            default: lvl = pick(-32768, 32767);
          endcase
          if (i < NumVerts) v[i][k] = lvl;
          else p[k] = lvl;
        end
      end
    end else begin
      // general triangle, point around the centroid and possibly off the plane
      for (int k = 0; k < NumAxes; k++) begin
        p[k] = (v[0][k] + v[1][k] + v[2][k]) / 3 + pick(-span, span);
      end
    end
    return pack_query(v, p);
  endfunction

  task automatic send_query(input query_t q);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    vertex0_x_i <= q.vert[0][0];
    vertex0_y_i <= q.vert[0][1];
    vertex0_z_i <= q.vert[0][2];
    vertex1_x_i <= q.vert[1][0];
    vertex1_y_i <= q.vert[1][1];
    vertex1_z_i <= q.vert[1][2];
    vertex2_x_i <= q.vert[2][0];
    vertex2_y_i <= q.vert[2][1];
    vertex2_z_i <= q.vert[2][2];
    point_x_i   <= q.pt[0];
    point_y_i   <= q.pt[1];
    point_z_i   <= q.pt[2];
    do @(posedge clk_i); while (busy_o);
    tracker.log_query(q);
  endtask

  task automatic drain_verdicts();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_query(random_query());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_query(make_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 0));
    send_query(make_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 256, 0));
    send_query(make_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 0, 0));
    send_query(make_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0));
    send_query(make_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 128, 0));
    send_query(make_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 512));
    send_query(make_query(0, 0, 0, 0, 256, 0, 256, 0, 0, 64, 64, 0));
    send_query(make_query(0, 0, 0, 256, 0, 0, 0, 256, 0, -32768, -32768, 32767));
    send_query(make_query(0, 0, 0, 100, 100, 100, 200, 200, 200, 5, 7, 9));
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, -32768, -32768, -32768));
    send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, -32768, -32768));
    send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 32767, 32767));
    send_query(make_query(-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0, 0, 0, 0));
    send_query(make_query(-32768, -32768, 0, 32767, -32768, 0,
                          0, 32767, 0, 32767, 32767, -32768));
    send_query(make_query(-32768, 32767, -32768, 32767, -32768, 32767,
                          32767, 32767, -32768, -32768, -32768, 32767));
    send_query(make_query(21845, 21845, 21845, -21846, -21846, -21846,
                          21845, -21846, 21845, -21846, 21845, -21846));
    send_query(make_query(1, -1, 0, -1, 1, 0, -1, -1, 0, -1, -1, 0));
    send_query(make_query(1, -1, 0, -1, 1, 0, -1, -1, 0, -2, 0, 0));
    send_query(make_query(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 10922, 10922, 10923));
    drain_verdicts();

    send_random(600);
    drain_verdicts();
    idle_pct = 0;
    send_random(400);
    idle_pct = 29;
    send_random(630);

    drain_verdicts();
    repeat (PipeDepth + 4) @(posedge clk_i);
    if (tracker.clean()) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
